/* sv/chi_pkg.sv */
package chi_pkg;

	// field widths
	localparam int VAL_W  = 32;
	localparam int POS_W  = 32;
	localparam int T_W    = 17;
	localparam int T_FRAC = 16;

	// powers of t
	localparam int T2_W = 2 * T_W - 1;
	localparam int T3_W = 3 * T_FRAC + 1;

	// basis weights: 48 fraction bits, |h| <= 1.0
	localparam int W_FRAC = 3 * T_FRAC;
	localparam int W_W    = W_FRAC + 2;
	localparam int W_INT  = W_W + 2;

	// weight split for the partial products
	localparam int WL_W = 24;
	localparam int WH_W = W_W - WL_W;
	localparam int PL_W = WL_W + 1 + VAL_W;
	localparam int PH_W = WH_W + VAL_W;

	// exact sum and the floored result before saturation
	localparam int SUM_W = W_W + VAL_W + 2;
	localparam int SH_W  = SUM_W - W_FRAC;

	localparam int N_TERM = 4;
	localparam int L_P0   = 0;
	localparam int L_M0   = 1;
	localparam int L_P1   = 2;
	localparam int L_M1   = 3;

	localparam logic [T_W-1:0]          T_ONE     = T_W'(1) << T_FRAC;
	localparam logic signed [W_INT-1:0] W_ONE_INT = W_INT'(1) <<< W_FRAC;
	localparam logic signed [W_W-1:0]   W_ONE     = W_W'(1) <<< W_FRAC;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [W_W-1:0]   wgt_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// floor by the weight fraction, then clip to the output range
	function automatic logic signed [POS_W-1:0] sat_pos(input sum_t s);
		logic signed [SH_W-1:0]  sh;
		logic signed [POS_W-1:0] r;
		sh = s[SUM_W-1:W_FRAC];
		if ((&sh[SH_W-1:POS_W-1]) || (~|sh[SH_W-1:POS_W-1])) begin
			r = sh[POS_W-1:0];
		end else if (sh[SH_W-1]) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(POS_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

/* sv/cubic_hermite_interpolator_unit.sv */
// Channel  Handshake               Beat payload
// in       in_valid / in_ready     start_point, start_tangent, end_point, end_tangent, param_t
// out      out_valid / out_ready   position
//
// Nine register stages, s1 to s9: a beat accepted into s1 moves through each stage in turn to the
// output register s9; while out_ready stays high, one beat enters and one leaves per cycle.
// The 25x32 and 26x32 multiplier banks and the three wide adder stages set the stage depth.
// Reset (arst_n low) clears every stage's valid bit; payload registers are not reset.
// Each stage holds while the stage after it is full and stalled; empty stages
// fill behind a stall, so in_ready stays high until all nine stages hold a beat.
module cubic_hermite_interpolator_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [chi_pkg::VAL_W-1:0]      start_point,
	input  logic signed [chi_pkg::VAL_W-1:0]      start_tangent,
	input  logic signed [chi_pkg::VAL_W-1:0]      end_point,
	input  logic signed [chi_pkg::VAL_W-1:0]      end_tangent,
	input  logic        [chi_pkg::T_W-1:0]        param_t,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [chi_pkg::POS_W-1:0]      position
);

	// valid bits and advance enables, one per stage
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9;

	// payload
	logic [chi_pkg::T_W-1:0]  t_in;
	logic [chi_pkg::T_W-1:0]  t_s1, t_s2, t_s3;
	logic [chi_pkg::T2_W-1:0] t2_s2, t2_s3;
	logic [chi_pkg::T3_W-1:0] t3_s3;
	chi_pkg::val_t v_s1 [chi_pkg::N_TERM];
	chi_pkg::val_t v_s2 [chi_pkg::N_TERM];
	chi_pkg::val_t v_s3 [chi_pkg::N_TERM];
	chi_pkg::val_t v_s4 [chi_pkg::N_TERM];
	chi_pkg::wgt_t h_s4 [chi_pkg::N_TERM];
	logic signed [chi_pkg::PL_W-1:0] pl_s5 [chi_pkg::N_TERM];
	logic signed [chi_pkg::PH_W-1:0] ph_s5 [chi_pkg::N_TERM];
	chi_pkg::sum_t term_s6 [chi_pkg::N_TERM];
	chi_pkg::sum_t pair_a_s7, pair_b_s7;
	chi_pkg::sum_t sum_s8;
	logic signed [chi_pkg::POS_W-1:0] pos_s9;

	// combinational stage logic
	logic signed [chi_pkg::W_INT-1:0] s3x, s2x, s1x;
	logic signed [chi_pkg::W_INT-1:0] h_int [chi_pkg::N_TERM];
	logic signed [chi_pkg::WL_W:0]    wl [chi_pkg::N_TERM];
	logic signed [chi_pkg::WH_W-1:0]  wh [chi_pkg::N_TERM];
	logic signed [chi_pkg::PL_W-1:0]  pl_c [chi_pkg::N_TERM];
	logic signed [chi_pkg::PH_W-1:0]  ph_c [chi_pkg::N_TERM];
	chi_pkg::sum_t pl_x [chi_pkg::N_TERM];
	chi_pkg::sum_t ph_x [chi_pkg::N_TERM];
	chi_pkg::sum_t term_c [chi_pkg::N_TERM];

	// A stage advances when it is empty or the stage after it advances.
	assign adv9     = !vld_s9 || out_ready;
	assign adv8     = !vld_s8 || adv9;
	assign adv7     = !vld_s7 || adv8;
	assign adv6     = !vld_s6 || adv7;
	assign adv5     = !vld_s5 || adv6;
	assign adv4     = !vld_s4 || adv5;
	assign adv3     = !vld_s3 || adv4;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign in_ready = adv1;

	assign out_valid = vld_s9;
	assign position  = pos_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
			if (adv7) vld_s7 <= vld_s6;
			if (adv8) vld_s8 <= vld_s7;
			if (adv9) vld_s9 <= vld_s8;
		end
	end

	// Clip t above one to exactly one.
	assign t_in = (param_t > chi_pkg::T_ONE) ? chi_pkg::T_ONE : param_t;

	// Hermite weights with 48 fraction bits:
	// h00 = 2t^3 - 3t^2 + 1, h10 = t^3 - 2t^2 + t, h01 = -2t^3 + 3t^2, h11 = t^3 - t^2
	always_comb begin
		s3x = {{(chi_pkg::W_INT - chi_pkg::T3_W){1'b0}}, t3_s3};
		s2x = {{(chi_pkg::W_INT - chi_pkg::T2_W - chi_pkg::T_FRAC){1'b0}},
			t2_s3, {chi_pkg::T_FRAC{1'b0}}};
		s1x = {{(chi_pkg::W_INT - chi_pkg::T_W - 2 * chi_pkg::T_FRAC){1'b0}},
			t_s3, {(2 * chi_pkg::T_FRAC){1'b0}}};
		h_int[chi_pkg::L_P0] = (s3x <<< 1) - ((s2x <<< 1) + s2x) + chi_pkg::W_ONE_INT;
		h_int[chi_pkg::L_M0] = s3x - (s2x <<< 1) + s1x;
		h_int[chi_pkg::L_P1] = ((s2x <<< 1) + s2x) - (s3x <<< 1);
		h_int[chi_pkg::L_M1] = s3x - s2x;
	end

	// Split each weight into an unsigned low part and a signed high part, and multiply each part by its value.
	always_comb begin
		for (int i = 0; i < chi_pkg::N_TERM; i++) begin
			wl[i]   = {1'b0, h_s4[i][chi_pkg::WL_W-1:0]};
			wh[i]   = h_s4[i][chi_pkg::W_W-1:chi_pkg::WL_W];
			pl_c[i] = wl[i] * v_s4[i];
			ph_c[i] = wh[i] * v_s4[i];
		end
	end

	// Recombine the partial products into exact weighted terms.
	always_comb begin
		for (int i = 0; i < chi_pkg::N_TERM; i++) begin
			pl_x[i]   = pl_s5[i];
			ph_x[i]   = ph_s5[i];
			term_c[i] = (ph_x[i] <<< chi_pkg::WL_W) + pl_x[i];
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: capture the beat, clip t
		if (adv1) begin
			t_s1                <= t_in;
			v_s1[chi_pkg::L_P0] <= start_point;
			v_s1[chi_pkg::L_M0] <= start_tangent;
			v_s1[chi_pkg::L_P1] <= end_point;
			v_s1[chi_pkg::L_M1] <= end_tangent;
		end
		// stage 2: t squared
		if (adv2) begin
			t_s2  <= t_s1;
			t2_s2 <= t_s1 * t_s1;
			v_s2  <= v_s1;
		end
		// stage 3: t cubed
		if (adv3) begin
			t_s3  <= t_s2;
			t2_s3 <= t2_s2;
			t3_s3 <= t2_s2 * t_s2;
			v_s3  <= v_s2;
		end
		// stage 4: basis weights
		if (adv4) begin
			for (int i = 0; i < chi_pkg::N_TERM; i++) begin
				h_s4[i] <= h_int[i][chi_pkg::W_W-1:0];
			end
			v_s4 <= v_s3;
		end
		// stage 5: partial products
		if (adv5) begin
			pl_s5 <= pl_c;
			ph_s5 <= ph_c;
		end
		// stage 6: weighted terms
		if (adv6) begin
			term_s6 <= term_c;
		end
		// stage 7: pair sums
		if (adv7) begin
			pair_a_s7 <= term_s6[chi_pkg::L_P0] + term_s6[chi_pkg::L_M0];
			pair_b_s7 <= term_s6[chi_pkg::L_P1] + term_s6[chi_pkg::L_M1];
		end
		// stage 8: exact sum
		if (adv8) begin
			sum_s8 <= pair_a_s7 + pair_b_s7;
		end
		// stage 9: floor and saturate into the output register
		if (adv9) begin
			pos_s9 <= chi_pkg::sat_pos(sum_s8);
		end
	end

`ifndef SYNTHESIS
	// The end weights always add up to exactly one.
	a_unity: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (h_s4[chi_pkg::L_P0] + h_s4[chi_pkg::L_P1]) == chi_pkg::W_ONE)
		else $error("end-point weights do not sum to one");

	// Tangent weights keep their signs: h10 >= 0, h11 <= 0.
	a_tan_sign: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> !h_s4[chi_pkg::L_M0][chi_pkg::W_W-1]
			&& (h_s4[chi_pkg::L_M1][chi_pkg::W_W-1] || h_s4[chi_pkg::L_M1] == '0))
		else $error("tangent weight has the wrong sign");

	// A full stage behind a stall keeps its beat.
	a_hold_s8: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && !adv9 |=> vld_s8 && $stable(sum_s8))
		else $error("stage 8 lost its beat under a stall");

	// Input is refused only when every stage holds a beat and the output stalls.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6
			&& vld_s7 && vld_s8 && vld_s9 && !out_ready)
		else $error("input refused with a bubble in the pipeline");
`endif

endmodule

/* bench/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import chi_pkg::*;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #6 clk = ~clk;

	// Input beat; every input starts at a known value
	logic                  in_valid      = 1'b0;
	logic                  in_ready;
	val_t                  start_point   = '0;
	val_t                  start_tangent = '0;
	val_t                  end_point     = '0;
	val_t                  end_tangent   = '0;
	logic [T_W-1:0]        param_t       = '0;

	// Output beat
	logic                  out_valid;
	logic                  out_ready     = 1'b0;
	logic signed [POS_W-1:0] position;

	// Positions still owed by the block, oldest first
	logic signed [POS_W-1:0] position_q[$];

	int mismatch_count = 0;
	// chance in a hundred that the sender or the receiver idles on a cycle
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	// cycles left of a forced receiver hold-off
	int hold_left      = 0;

	localparam val_t COORD_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t COORD_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [T_W-1:0] T_HALF = T_ONE >> 1;

	cubic_hermite_interpolator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_point   (start_point),
		.start_tangent (start_tangent),
		.end_point     (end_point),
		.end_tangent   (end_tangent),
		.param_t       (param_t),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.position      (position)
	);

	// Hermite evaluation at full precision. Weights carry W_FRAC fraction bits,
	// so the weighted sum carries W_FRAC + 8; an arithmetic shift by W_FRAC
	// floors it back to 8 fraction bits before clipping to 32 bits.
	function automatic logic signed [POS_W-1:0] hermite_position(
		input val_t           p0,
		input val_t           m0,
		input val_t           p1,
		input val_t           m1,
		input logic [T_W-1:0] t_raw
	);
		logic signed [127:0] t, s1, s2, s3, one;
		logic signed [127:0] h00, h10, h01, h11;
		logic signed [127:0] v0, v1, v2, v3;
		logic signed [127:0] acc, floored;
		logic signed [127:0] lim_hi, lim_lo;
		// parameters above one are clamped to exactly one
		t       = (t_raw > T_ONE) ? 128'(T_ONE) : 128'(t_raw);
		s3      = t * t * t;
		s2      = (t * t) <<< T_FRAC;
		s1      = t <<< (2 * T_FRAC);
		one     = 128'sd1 <<< W_FRAC;
		h00     = 2 * s3 - 3 * s2 + one;
		h10     = s3 - 2 * s2 + s1;
		h01     = 3 * s2 - 2 * s3;
		h11     = s3 - s2;
		v0      = p0;
		v1      = m0;
		v2      = p1;
		v3      = m1;
		acc     = h00 * v0 + h10 * v1 + h01 * v2 + h11 * v3;
		floored = acc >>> W_FRAC;
		lim_hi  = COORD_MAX;
		lim_lo  = COORD_MIN;
		if (floored > lim_hi) begin
			return COORD_MAX;
		end else if (floored < lim_lo) begin
			return COORD_MIN;
		end
		return floored[POS_W-1:0];
	endfunction

	// Receiver: a forced hold-off wins over the random idle chance
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left  = hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each output beat with the oldest owed position
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (position_q.size() == 0) begin
				$error("position: expected none, got %0d", position);
				mismatch_count++;
			end else begin
				if (position !== position_q[0]) begin
					$error("position: expected %0d, got %0d", position_q[0], position);
					mismatch_count++;
				end
				void'(position_q.pop_front());
			end
		end
	end

	// Offer one beat, idling first at the sender's rate, and hold it until taken.
	// Valid is only lowered when a gap is taken, so back-to-back beats keep it high.
	task automatic send_beat(
		input val_t           p0,
		input val_t           m0,
		input val_t           p1,
		input val_t           m1,
		input logic [T_W-1:0] t
	);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		start_point   <= p0;
		start_tangent <= m0;
		end_point     <= p1;
		end_tangent   <= m1;
		param_t       <= t;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		position_q.push_back(hermite_position(p0, m0, p1, m1, t));
	endtask

	// Drop valid and hold off until every owed position has come back
	task automatic drain;
		in_valid <= 1'b0;
		while (position_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Mostly moderate coordinates, some full-range, some at the extremes
	function automatic val_t rand_coord();
		val_t v;
		v = $urandom;
		case ($urandom_range(7))
			0: v = COORD_MAX;
			1: v = COORD_MIN;
			2, 3: ;
			default: v = v >>> $urandom_range(28, 8);
		endcase
		return v;
	endfunction

	// Mostly inside [0, 1], with the ends and the clamped range now and then
	function automatic logic [T_W-1:0] rand_param();
		case ($urandom_range(19))
			0: return '0;
			1: return T_ONE;
			2, 3: return T_W'($urandom_range(2 ** T_W - 1, T_ONE + 1));
			default: return T_W'($urandom_range(T_ONE, 0));
		endcase
	endfunction

	// Curve ends, parameter clamping, saturation both ways and floor rounding
	task automatic test_directed;
		send_beat('0, '0, '0, '0, '0);
		send_beat(COORD_MAX, '0, '0, '0, '0);
		send_beat(COORD_MIN, '0, '0, '0, '0);
		send_beat('0, COORD_MAX, COORD_MAX, COORD_MIN, T_ONE);
		send_beat(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, T_ONE);
		// parameter above one behaves as one
		send_beat(32'sd100, 32'sd7, 32'sd12345, -32'sd9, T_W'(T_ONE + 1));
		send_beat(32'sd100, 32'sd7, 32'sd12345, -32'sd9, {T_W{1'b1}});
		send_beat(32'sd256, '0, 32'sd512, '0, T_HALF);
		send_beat('0, COORD_MAX, '0, COORD_MIN, T_HALF);
		send_beat('0, COORD_MIN, '0, COORD_MAX, T_HALF);
		// push past the top and the bottom of the output range
		send_beat(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, T_HALF);
		send_beat(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, T_HALF);
		send_beat(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, T_W'(1));
		// half an LSB below zero floors to minus one; above zero floors to zero
		send_beat(-32'sd1, '0, '0, '0, T_HALF);
		send_beat(32'sd1, '0, '0, '0, T_HALF);
		send_beat(-32'sd1, -32'sd1, -32'sd1, -32'sd1, T_W'(1));
		send_beat(-32'sd1, -32'sd1, -32'sd1, -32'sd1, T_W'(T_ONE - 1));
		send_beat(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333, 32'shCCCC_CCCC,
			T_W'(17'h15555));
		drain();
	endtask

	// Independent beats with random content
	task automatic test_random(input int count);
		repeat (count) begin
			send_beat(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_param());
		end
		drain();
	endtask

	// Walk a few curves end to end, three components each, as a sampler would
	task automatic test_curve_sweep(input int curves);
		val_t p0, m0, p1, m1;
		repeat (curves * 3) begin
			p0 = val_t'($signed($urandom)) >>> 12;
			m0 = val_t'($signed($urandom)) >>> 12;
			p1 = val_t'($signed($urandom)) >>> 12;
			m1 = val_t'($signed($urandom)) >>> 12;
			for (int i = 0; i <= 8; i++) begin
				send_beat(p0, m0, p1, m1, T_W'(i * (T_ONE / 8)));
			end
		end
		drain();
	endtask

	// Stall the receiver long enough for the pipe to fill and in_ready to drop,
	// keep offering beats throughout, then pause until all results are back
	task automatic test_backpressure(input int count);
		hold_left = 150;
		repeat (count) begin
			send_beat(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_param());
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// slow receiver, eager sender
		send_idle_pct = 14;
		recv_idle_pct = 87;
		test_directed();
		test_random(150);

		// slow sender, eager receiver
		send_idle_pct = 87;
		recv_idle_pct = 14;
		test_random(150);

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_curve_sweep(2);
		test_backpressure(40);
		test_random(150);

		// let any stray beat surface before the verdict
		repeat (30) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("cubic_hermite_interpolator_unit regression: pass");
		end else begin
			$display("cubic_hermite_interpolator_unit regression: fail");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("cubic_hermite_interpolator_unit regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
sv/chi_pkg.sv
sv/cubic_hermite_interpolator_unit.sv
bench/testbench.sv
